@@ hdl/osw_pkg.sv @@
// Shared types and constants for the order-statistic window filter.
package osw_pkg;

    localparam int WIN_SIDE  = 3;
    localparam int WIN_COUNT = WIN_SIDE * WIN_SIDE;
    localparam int PIX_W     = 8;
    localparam int RANK_W    = $clog2(WIN_COUNT);
    localparam int MAX_TRIM  = (WIN_COUNT - 1) / 2;
    localparam int CFG_W     = 3;
    localparam int TDATA_W   = ((WIN_COUNT * PIX_W + 7) / 8) * 8;

    typedef enum logic [CFG_W-1:0] {
        MODE_MEDIAN   = 3'd0,
        MODE_MAXIMUM  = 3'd1,
        MODE_MINIMUM  = 3'd2,
        MODE_MIDPOINT = 3'd3,
        MODE_TRIMMED  = 3'd4
    } t_mode;

    localparam logic CFG_FILTER_MODE = 1'b0;
    localparam logic CFG_TRIM_DEPTH  = 1'b1;

    typedef logic [WIN_COUNT-1:0][PIX_W-1:0] t_window;

    // Pair of ranks whose values are averaged into the output pixel.
    typedef struct packed {
        logic [RANK_W-1:0] lo;
        logic [RANK_W-1:0] hi;
    } t_rank_sel;

endpackage

@@ hdl/osw_rank_select.sv @@
// Rank the nine window pixels and average the two selected ranks.
module osw_rank_select (
    input  osw_pkg::t_window            i_window,
    input  osw_pkg::t_rank_sel          i_sel,
    output logic [osw_pkg::PIX_W-1:0]   o_pixel
);

    logic [osw_pkg::WIN_COUNT-1:0][osw_pkg::RANK_W-1:0] rank;
    logic [osw_pkg::PIX_W-1:0]                          lo_val;
    logic [osw_pkg::PIX_W-1:0]                          hi_val;
    logic [osw_pkg::PIX_W:0]                            sum;

    // Ties are broken by position so every pixel gets a unique rank.
    always_comb begin
        for (int i = 0; i < osw_pkg::WIN_COUNT; i++) begin
            rank[i] = '0;
            for (int j = 0; j < osw_pkg::WIN_COUNT; j++) begin
                if (j < i) begin
                    if (i_window[j] <= i_window[i]) begin
                        rank[i] = rank[i] + 1'b1;
                    end
                end else if (j > i) begin
                    if (i_window[j] < i_window[i]) begin
                        rank[i] = rank[i] + 1'b1;
                    end
                end
            end
        end
    end

    always_comb begin
        lo_val = '0;
        hi_val = '0;
        for (int i = 0; i < osw_pkg::WIN_COUNT; i++) begin
            if (rank[i] == i_sel.lo) begin
                lo_val = lo_val | i_window[i];
            end
            if (rank[i] == i_sel.hi) begin
                hi_val = hi_val | i_window[i];
            end
        end
    end

    assign sum     = {1'b0, lo_val} + {1'b0, hi_val};
    assign o_pixel = sum[osw_pkg::PIX_W:1];

endmodule

@@ hdl/order_statistic_window_filter_top.sv @@
// An accepted input beat passes through the input register and then the result register to its output beat.
// Throughput: one 3x3 window per cycle; the input register and the result
// register each advance whenever the result register is empty or drained.
// Reset (synchronous, active low) empties both stages and sets the mode to
// median and the trim depth to one.
module order_statistic_window_filter_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // pix_top_left, pix_top_mid, pix_top_right, pix_mid_left, pix_center,
    // pix_mid_right, pix_bottom_left, pix_bottom_mid, pix_bottom_right
    input  logic [osw_pkg::TDATA_W-1:0]   s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // filtered_pixel
    output logic [osw_pkg::PIX_W-1:0]     m_axis_tdata,
    input  logic                          i_cfg_wr_en,
    input  logic                          i_cfg_index,
    input  logic [osw_pkg::CFG_W-1:0]     i_cfg_wdata
);

    osw_pkg::t_mode              r_filter_mode;
    logic [osw_pkg::CFG_W-1:0]   r_trim_depth;

    logic                        r_v1;
    osw_pkg::t_window            r_window;
    osw_pkg::t_rank_sel          r_sel;
    osw_pkg::t_rank_sel          n_sel;

    logic                        r_v2;
    logic [osw_pkg::PIX_W-1:0]   r_result;
    logic [osw_pkg::PIX_W-1:0]   n_result;

    logic                        out_free;
    logic [osw_pkg::RANK_W-1:0]  trim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_mode <= osw_pkg::MODE_MEDIAN;
            r_trim_depth  <= osw_pkg::CFG_W'(1);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                osw_pkg::CFG_FILTER_MODE: r_filter_mode <= osw_pkg::t_mode'(i_cfg_wdata);
                osw_pkg::CFG_TRIM_DEPTH:  r_trim_depth  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Saturate the trim so the inner ranks never cross the median.
    assign trim = (r_trim_depth > osw_pkg::CFG_W'(osw_pkg::MAX_TRIM))
                ? osw_pkg::RANK_W'(osw_pkg::MAX_TRIM)
                : osw_pkg::RANK_W'(r_trim_depth);

    always_comb begin
        case (r_filter_mode)
            osw_pkg::MODE_MAXIMUM: begin
                n_sel.lo = osw_pkg::RANK_W'(osw_pkg::WIN_COUNT - 1);
                n_sel.hi = osw_pkg::RANK_W'(osw_pkg::WIN_COUNT - 1);
            end
            osw_pkg::MODE_MINIMUM: begin
                n_sel.lo = '0;
                n_sel.hi = '0;
            end
            osw_pkg::MODE_MIDPOINT: begin
                n_sel.lo = '0;
                n_sel.hi = osw_pkg::RANK_W'(osw_pkg::WIN_COUNT - 1);
            end
            osw_pkg::MODE_TRIMMED: begin
                n_sel.lo = trim;
                n_sel.hi = osw_pkg::RANK_W'(osw_pkg::WIN_COUNT - 1) - trim;
            end
            default: begin
                n_sel.lo = osw_pkg::RANK_W'(osw_pkg::WIN_COUNT / 2);
                n_sel.hi = osw_pkg::RANK_W'(osw_pkg::WIN_COUNT / 2);
            end
        endcase
    end

    assign out_free      = !r_v2 || m_axis_tready;
    assign s_axis_tready = !r_v1 || out_free;

    // Input stage: capture the window beat and the rank pair.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (s_axis_tready) begin
            r_v1 <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_window <= osw_pkg::t_window'(s_axis_tdata[osw_pkg::WIN_COUNT*osw_pkg::PIX_W-1:0]);
            r_sel    <= n_sel;
        end
    end

    osw_rank_select u_rank_select (
        .i_window (r_window),
        .i_sel    (r_sel),
        .o_pixel  (n_result)
    );

    // Result stage: advance when empty or when the output beat is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (out_free) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_v1) begin
            r_result <= n_result;
        end
    end

    assign m_axis_tvalid = r_v2;
    assign m_axis_tdata  = r_result;

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("pipeline not empty after reset");

    a_ready_when_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while result register is empty");

    a_stage_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && out_free |=> m_axis_tvalid)
        else $error("input stage beat lost on its way to the result register");

    a_rank_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> r_sel.lo <= r_sel.hi)
        else $error("selected low rank above high rank");

endmodule
